[rtl/core/v3mu_pkg.sv]
// ----------------------------------------------------------------------------
// v3mu_pkg
// Shared constants, types and helpers of the 3D vector math unit.
// ----------------------------------------------------------------------------
`default_nettype none

package v3mu_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 32;
    localparam int CORDIC_STEPS = 30;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
    localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

    localparam logic [31:0] Q30_ONE     = 32'd1073741824;
    localparam logic [31:0] Q30_HALF_PI = 32'd1686629713;
    localparam logic [31:0] Q30_PI      = 32'd3373259426;
    localparam logic [29:0] RADDEG_Q24  = 30'd961263669;

    typedef enum logic [3:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_NEGATE    = 4'd2,
        OP_SCALE     = 4'd3,
        OP_DOT       = 4'd4,
        OP_CROSS     = 4'd5,
        OP_LENGTH    = 4'd6,
        OP_NORMALIZE = 4'd7,
        OP_PROJECT   = 4'd8,
        OP_ANGLE     = 4'd9,
        OP_REFLECT   = 4'd10,
        OP_EQUALS    = 4'd11
    } t_op;

    // item state that travels beside the datapath
    typedef struct packed {
        logic               vld;
        t_op                op;
        logic               deg;
        logic               zl;
        logic               eq;
        logic               flag;
        logic               dneg;
        logic [63:0]        dmag;
        logic [2:0][31:0]   a;
        logic [2:0][31:0]   r;
        logic signed [31:0] rs;
        logic signed [31:0] cval;
    } t_meta;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > WIDE_MAX) res = S32_MAX;
        else if (v < WIDE_MIN) res = S32_MIN;
        else res = v[31:0];
        return res;
    endfunction

    function automatic logic signed [31:0] from_mag(input logic neg, input logic [31:0] m);
        logic signed [31:0] res;
        if (neg) res = (m > 32'h80000000) ? S32_MIN : $signed(-m);
        else res = m[31] ? S32_MAX : $signed(m);
        return res;
    endfunction

    // rotation angle of cordic step k in Q4.30
    function automatic logic [33:0] atan_step(input int k);
        logic [33:0] res;
        case (k)
            0:       res = 34'd843314857;
            1:       res = 34'd497837829;
            2:       res = 34'd263043836;
            3:       res = 34'd133525158;
            4:       res = 34'd67021686;
            5:       res = 34'd33543515;
            6:       res = 34'd16775850;
            7:       res = 34'd8388437;
            8:       res = 34'd4194282;
            9:       res = 34'd2097149;
            10:      res = 34'd1048575;
            default: res = 34'd1 << (30 - k);
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/v3mu_isqrt.sv]
// ----------------------------------------------------------------------------
// v3mu_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3mu_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);

    localparam int N = v3mu_pkg::SQRT_STEPS;

    logic [63:0] r_rem [N];
    logic [63:0] r_res [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] w_rem, w_res, w_t, n_rem, n_res;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_rem = i_val;
            assign w_res = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_res = r_res[k-1];
        end

        assign w_t   = w_res + BIT;
        assign w_ge  = w_rem >= w_t;
        assign n_rem = w_ge ? w_rem - w_t : w_rem;
        assign n_res = w_ge ? (w_res >> 1) + BIT : w_res >> 1;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_res[k] <= n_res;
            end
        end
    end

    assign o_root = r_res[N-1][31:0];

endmodule

`default_nettype wire

[rtl/core/v3mu_div.sv]
// ----------------------------------------------------------------------------
// v3mu_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3mu_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rem,
    input  logic [31:0] i_num,
    input  logic [63:0] i_den,
    output logic [31:0] o_quo
);

    localparam int N = v3mu_pkg::DIV_STEPS;

    logic [63:0] r_rem [N];
    logic [31:0] r_num [N];
    logic [63:0] r_den [N];
    logic [31:0] r_quo [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [63:0] w_rem, w_den;
        logic [31:0] w_num, w_quo;
        logic [64:0] w_t;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_rem = i_rem;
            assign w_num = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_num = r_num[k-1];
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign w_t  = {w_rem, w_num[31]};
        assign w_ge = w_t >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? 64'(w_t - {1'b0, w_den}) : w_t[63:0];
                r_num[k] <= {w_num[30:0], 1'b0};
                r_den[k] <= w_den;
                r_quo[k] <= {w_quo[30:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[N-1];

endmodule

`default_nettype wire

[rtl/core/vector3_math_unit.sv]
// ----------------------------------------------------------------------------
// vector3_math_unit
// Stateless 3D vector ALU on signed Q16.16 operands, fully pipelined.
// ----------------------------------------------------------------------------
// depth: 132 register stages from accept to the output register; set by the
//   32-stage square roots, the 32-stage dividers and the 30-stage cordic
// throughput: one item per cycle while the output is not stalled, every stage is a register
// a stalled output freezes the whole pipe, nothing is lost or repeated
// reset: synchronous active-low i_rst_n clears all valid bits
`default_nettype none

module vector3_math_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,  // ax, ay, az, bx, by, bz, scale_factor
    input  logic [7:0]   s_axis_tuser,  // op[3:0], in_degrees[4], zero
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // res_x, res_y, res_z, res_scalar
    output logic [7:0]   m_axis_tuser   // is_equal[0], zero_length[1], zero
);

    localparam int NSQ = v3mu_pkg::SQRT_STEPS;
    localparam int NDV = v3mu_pkg::DIV_STEPS;
    localparam int NCO = v3mu_pkg::CORDIC_STEPS;
    localparam logic [63:0] ONE_SQ = 64'd1 << 60;

    logic w_en;
    v3mu_pkg::t_meta r_out;

    assign w_en          = !r_out.vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // ---------------- stage 1: products, add, sub, negate and equals ----------------
    logic signed [31:0] w_a [3];
    logic signed [31:0] w_b [3];
    logic signed [31:0] w_sf;
    logic signed [63:0] r_aa [3], r_bb [3], r_ab [3], r_as [3], r_cp [3], r_cn [3];
    logic signed [31:0] r_b1 [3];
    v3mu_pkg::t_meta n_m1, r_m1;

    assign w_sf = s_axis_tdata[223:192];

    always_comb begin
        n_m1     = '0;
        n_m1.vld = s_axis_tvalid;
        n_m1.op  = v3mu_pkg::t_op'(s_axis_tuser[3:0]);
        n_m1.deg = s_axis_tuser[4];
        for (int i = 0; i < 3; i++) begin
            n_m1.a[i] = w_a[i];
        end
        unique case (n_m1.op)
            v3mu_pkg::OP_ADD: begin
                for (int i = 0; i < 3; i++)
                    n_m1.r[i] = v3mu_pkg::sat32(66'(w_a[i]) + 66'(w_b[i]));
            end
            v3mu_pkg::OP_SUB: begin
                for (int i = 0; i < 3; i++)
                    n_m1.r[i] = v3mu_pkg::sat32(66'(w_a[i]) - 66'(w_b[i]));
            end
            v3mu_pkg::OP_NEGATE: begin
                for (int i = 0; i < 3; i++)
                    n_m1.r[i] = v3mu_pkg::sat32(-66'(w_a[i]));
            end
            v3mu_pkg::OP_EQUALS: begin
                n_m1.eq = (w_a[0] == w_b[0]) && (w_a[1] == w_b[1]) && (w_a[2] == w_b[2]);
            end
            default: ;
        endcase
    end

    for (genvar i = 0; i < 3; i++) begin : g_mul
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        assign w_a[i] = s_axis_tdata[32*i +: 32];
        assign w_b[i] = s_axis_tdata[96 + 32*i +: 32];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_aa[i] <= w_a[i] * w_a[i];
                r_bb[i] <= w_b[i] * w_b[i];
                r_ab[i] <= w_a[i] * w_b[i];
                r_as[i] <= w_a[i] * w_sf;
                r_cp[i] <= w_a[J] * w_b[K];
                r_cn[i] <= w_b[J] * w_a[K];
                r_b1[i] <= w_b[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m1.vld <= 1'b0;
        else if (w_en) r_m1 <= n_m1;
    end

    // ---------------- stage 2: sums and rounding ----------------
    logic signed [65:0] w_dot, w_dabs;
    logic signed [31:0] w_dr;
    logic [63:0]        r_sa, r_sb;
    logic signed [31:0] r_d2;
    logic signed [31:0] r_b2 [3];
    v3mu_pkg::t_meta n_m2, r_m2;

    assign w_dot  = 66'(r_ab[0]) + 66'(r_ab[1]) + 66'(r_ab[2]);
    assign w_dabs = w_dot[65] ? -w_dot : w_dot;
    assign w_dr   = v3mu_pkg::sat32((w_dot + 66'sd32768) >>> 16);

    always_comb begin
        n_m2      = r_m1;
        n_m2.dneg = w_dot[65];
        n_m2.dmag = w_dabs[63:0];
        unique case (r_m1.op)
            v3mu_pkg::OP_SCALE: begin
                for (int i = 0; i < 3; i++)
                    n_m2.r[i] = v3mu_pkg::sat32((66'(r_as[i]) + 66'sd32768) >>> 16);
            end
            v3mu_pkg::OP_CROSS: begin
                for (int i = 0; i < 3; i++)
                    n_m2.r[i] = v3mu_pkg::sat32(
                        (66'(r_cp[i]) - 66'(r_cn[i]) + 66'sd32768) >>> 16);
            end
            v3mu_pkg::OP_DOT: n_m2.rs = w_dr;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa <= $unsigned(r_aa[0]) + $unsigned(r_aa[1]) + $unsigned(r_aa[2]);
            r_sb <= $unsigned(r_bb[0]) + $unsigned(r_bb[1]) + $unsigned(r_bb[2]);
            r_d2 <= w_dr;
            for (int i = 0; i < 3; i++) r_b2[i] <= r_b1[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m2.vld <= 1'b0;
        else if (w_en) r_m2 <= n_m2;
    end

    // ---------------- stages 3..34: lengths of a and b ----------------
    logic [31:0] w_la, w_lb;

    v3mu_isqrt u_sqrt_a (.i_clk(i_clk), .i_en(w_en), .i_val(r_sa), .o_root(w_la));
    v3mu_isqrt u_sqrt_b (.i_clk(i_clk), .i_en(w_en), .i_val(r_sb), .o_root(w_lb));

    v3mu_pkg::t_meta r_mq [NSQ];
    v3mu_pkg::t_meta n_mq1;
    logic signed [63:0] r_rp [3];

    // reflect runs beside the square roots: n * d, then a - 2dn
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) r_rp[i] <= r_b2[i] * r_d2;
        end
    end

    always_comb begin
        n_mq1 = r_mq[0];
        if (r_mq[0].op == v3mu_pkg::OP_REFLECT) begin
            for (int i = 0; i < 3; i++)
                n_mq1.r[i] = v3mu_pkg::sat32(66'($signed(r_mq[0].a[i]))
                                             - ((66'(r_rp[i]) + 66'sd16384) >>> 15));
        end
    end

    for (genvar k = 0; k < NSQ; k++) begin : g_mq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_mq[k].vld <= 1'b0;
            else if (w_en) begin
                if (k == 0) r_mq[k] <= r_m2;
                else if (k == 1) r_mq[k] <= n_mq1;
                else r_mq[k] <= r_mq[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ---------------- stage 35: length result, zero checks, la*lb ----------------
    logic [31:0] r_la, r_lb;
    logic [63:0] r_p;
    v3mu_pkg::t_meta n_m35, r_m35;

    always_comb begin
        n_m35 = r_mq[NSQ-1];
        unique case (n_m35.op)
            v3mu_pkg::OP_LENGTH:    n_m35.rs = w_la[31] ? v3mu_pkg::S32_MAX : $signed(w_la);
            v3mu_pkg::OP_NORMALIZE: n_m35.zl = (w_la == '0);
            v3mu_pkg::OP_PROJECT:   n_m35.zl = (w_lb == '0);
            v3mu_pkg::OP_ANGLE:     n_m35.zl = (w_la == '0) || (w_lb == '0);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_la <= w_la;
            r_lb <= w_lb;
            r_p  <= w_la * w_lb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m35.vld <= 1'b0;
        else if (w_en) r_m35 <= n_m35;
    end

    // ---------------- stages 36..67: divisions ----------------
    logic [48:0] w_na [3];
    logic [31:0] w_qn [3];
    logic [64:0] w_n8;
    logic        w_ovf, w_cone;
    logic [63:0] w_prem, w_pden, w_pden_q;
    logic [31:0] w_pnum, w_qp;
    v3mu_pkg::t_meta n_md0;
    v3mu_pkg::t_meta r_md [NDV];

    for (genvar i = 0; i < 3; i++) begin : g_norm
        logic signed [31:0] w_ai;
        logic [31:0]        w_mag;

        assign w_ai    = $signed(r_m35.a[i]);
        assign w_mag   = w_ai[31] ? 32'(-w_ai) : w_ai;
        // (|a| << 16) + la / 2, quotient stays below 2^17
        assign w_na[i] = {1'b0, w_mag, 16'b0} + 49'(r_la >> 1);

        v3mu_div u_div_n (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (64'(w_na[i][48:32])),
            .i_num (w_na[i][31:0]),
            .i_den ({32'b0, r_la}),
            .o_quo (w_qn[i])
        );
    end

    assign w_n8     = {1'b0, r_m35.dmag} + 65'(r_lb >> 1);
    assign w_ovf    = w_n8[64:32] >= {1'b0, r_lb};
    assign w_cone   = r_m35.dmag >= r_p;
    assign w_pden_q = {32'b0, r_lb};

    // angle divides |dot| * 2^32 by la*lb, project divides |dot| + lb/2 by lb
    always_comb begin
        n_md0 = r_m35;
        if (r_m35.op == v3mu_pkg::OP_ANGLE) begin
            w_prem     = r_m35.dmag;
            w_pnum     = '0;
            w_pden     = r_p;
            n_md0.flag = w_cone;
        end else begin
            w_prem     = 64'(w_n8[64:32]);
            w_pnum     = w_n8[31:0];
            w_pden     = w_pden_q;
            n_md0.flag = w_ovf;
        end
    end

    v3mu_div u_div_p (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (w_prem),
        .i_num (w_pnum),
        .i_den (w_pden),
        .o_quo (w_qp)
    );

    for (genvar k = 0; k < NDV; k++) begin : g_md
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_md[k].vld <= 1'b0;
            else if (w_en) r_md[k] <= (k == 0) ? n_md0 : r_md[(k == 0) ? 0 : k-1];
        end
    end

    // ---------------- stage 68: quotients to results, cosine squared ----------------
    logic [30:0] w_cmag;
    logic [61:0] r_c2;
    v3mu_pkg::t_meta n_m68, r_m68;

    assign w_cmag = r_md[NDV-1].flag ? v3mu_pkg::Q30_ONE[30:0] : {1'b0, w_qp[31:2]};

    always_comb begin
        n_m68 = r_md[NDV-1];
        if (!n_m68.zl) begin
            unique case (n_m68.op)
                v3mu_pkg::OP_NORMALIZE: begin
                    for (int i = 0; i < 3; i++)
                        n_m68.r[i] = v3mu_pkg::from_mag(n_m68.a[i][31], w_qn[i]);
                end
                v3mu_pkg::OP_PROJECT: begin
                    if (n_m68.flag)
                        n_m68.rs = n_m68.dneg ? v3mu_pkg::S32_MIN : v3mu_pkg::S32_MAX;
                    else
                        n_m68.rs = v3mu_pkg::from_mag(n_m68.dneg, w_qp);
                end
                v3mu_pkg::OP_ANGLE: begin
                    n_m68.cval = n_m68.dneg ? -$signed({1'b0, w_cmag})
                                            : $signed({1'b0, w_cmag});
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_c2 <= w_cmag * w_cmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m68.vld <= 1'b0;
        else if (w_en) r_m68 <= n_m68;
    end

    // ---------------- stages 69..100: sine = sqrt(1 - c^2) ----------------
    logic [31:0] w_s;
    v3mu_pkg::t_meta r_mc [NSQ];

    v3mu_isqrt u_sqrt_c (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (ONE_SQ - 64'(r_c2)),
        .o_root (w_s)
    );

    for (genvar k = 0; k < NSQ; k++) begin : g_mc
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_mc[k].vld <= 1'b0;
            else if (w_en) r_mc[k] <= (k == 0) ? r_m68 : r_mc[(k == 0) ? 0 : k-1];
        end
    end

    // ---------------- stages 101..130: cordic vectoring ----------------
    logic signed [31:0] w_c;
    logic signed [33:0] w_x0, w_y0, w_z0;
    logic signed [33:0] r_cx [NCO], r_cy [NCO], r_cz [NCO];
    v3mu_pkg::t_meta r_mk [NCO];

    assign w_c = r_mc[NSQ-1].cval;

    // negative cosine starts from a quarter turn
    always_comb begin
        if (!w_c[31]) begin
            w_x0 = 34'(w_c);
            w_y0 = $signed(34'(w_s));
            w_z0 = '0;
        end else begin
            w_x0 = $signed(34'(w_s));
            w_y0 = -34'(w_c);
            w_z0 = $signed(34'(v3mu_pkg::Q30_HALF_PI));
        end
    end

    for (genvar k = 0; k < NCO; k++) begin : g_cordic
        logic signed [33:0] w_x, w_y, w_z, w_dx, w_dy, w_st;

        if (k == 0) begin : g_first
            assign w_x = w_x0;
            assign w_y = w_y0;
            assign w_z = w_z0;
        end else begin : g_next
            assign w_x = r_cx[k-1];
            assign w_y = r_cy[k-1];
            assign w_z = r_cz[k-1];
        end

        assign w_dx = w_y >>> k;
        assign w_dy = w_x >>> k;
        assign w_st = $signed(v3mu_pkg::atan_step(k));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_y > 0) begin
                    r_cx[k] <= w_x + w_dx;
                    r_cy[k] <= w_y - w_dy;
                    r_cz[k] <= w_z + w_st;
                end else begin
                    r_cx[k] <= w_x - w_dx;
                    r_cy[k] <= w_y + w_dy;
                    r_cz[k] <= w_z - w_st;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_mk[k].vld <= 1'b0;
            else if (w_en) r_mk[k] <= (k == 0) ? r_mc[NSQ-1] : r_mk[(k == 0) ? 0 : k-1];
        end
    end

    // ---------------- stage 131: clamp angle, degree product ----------------
    logic signed [33:0] w_zf;
    logic [31:0]        w_zc, r_zc;
    logic [61:0]        r_prod;
    v3mu_pkg::t_meta    r_m131;

    assign w_zf = r_cz[NCO-1];

    always_comb begin
        if (w_zf < 0) w_zc = '0;
        else if (w_zf > $signed(34'(v3mu_pkg::Q30_PI))) w_zc = v3mu_pkg::Q30_PI;
        else w_zc = w_zf[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zc   <= w_zc;
            r_prod <= w_zc * v3mu_pkg::RADDEG_Q24;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m131.vld <= 1'b0;
        else if (w_en) r_m131 <= r_mk[NCO-1];
    end

    // ---------------- stage 132: output register ----------------
    logic [62:0]     w_deg;
    logic [32:0]     w_rad;
    v3mu_pkg::t_meta n_out;

    assign w_deg = 63'(r_prod) + (63'd1 << 37);
    assign w_rad = 33'(r_zc) + 33'd8192;

    always_comb begin
        n_out = r_m131;
        if (r_m131.op == v3mu_pkg::OP_ANGLE && !r_m131.zl)
            n_out.rs = r_m131.deg ? $signed(32'(w_deg >> 38)) : $signed(32'(w_rad >> 14));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out.vld <= 1'b0;
        else if (w_en) r_out <= n_out;
    end

    assign m_axis_tvalid = r_out.vld;
    assign m_axis_tdata  = {r_out.rs, r_out.r[2], r_out.r[1], r_out.r[0]};
    assign m_axis_tuser  = {6'b0, r_out.zl, r_out.eq};

endmodule

`default_nettype wire

[rtl/core/v3mu_checker.sv]
// ----------------------------------------------------------------------------
// v3mu_checker
// Port-level checks of the vector math unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module v3mu_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [7:0]   m_axis_tuser
);

    // input side moves exactly when the output register can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled item changed");

    // zero length forces every result to zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
        else $error("zero length item carries data");

    a_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("equals item carries data");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind vector3_math_unit v3mu_checker u_v3mu_checker (.*);

`default_nettype wire

[dv/vector3_math_unit_checker.sv]
// ----------------------------------------------------------------------------
// vector3_math_unit_checker
// Watches both streams of the vector math unit, predicts the result of every
// accepted item and compares it, field by field, with the results leaving the
// block in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vector3_math_unit_checker
    import v3mu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [223:0] i_in_data,
    input  logic [7:0]   i_in_user,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [127:0] i_out_data,
    input  logic [7:0]   i_out_user,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] s;
        logic        eq;
        logic        zl;
    } t_vec_result;

    typedef logic signed [127:0] t_wide;

    t_vec_result result_queue[$];

    function automatic logic [31:0] clamp32(input t_wide v);
        if (v > 128'sd2147483647) return 32'h7fffffff;
        if (v < -128'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic t_wide signed_from_mag(input logic neg, input t_wide m);
        return neg ? -m : m;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned vec_length(input t_wide v[3]);
        t_wide sq;
        sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        return floor_root(sq[63:0]);
    endfunction

    // arccosine of a Q2.30 cosine by vectoring rotations
    function automatic longint arc_cos(input longint c);
        longint s, x, y, z, step, dx, dy;
        longint atan_tab[11];
        atan_tab = '{843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
                     16775850, 8388437, 4194282, 2097149, 1048575};
        s = longint'(floor_root(64'(64'sd1152921504606846976 - c * c)));
        if (c >= 0) begin
            x = c; y = s; z = 0;
        end else begin
            x = s; y = -c; z = longint'(Q30_HALF_PI);
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            step = (i < 11) ? atan_tab[i] : (64'sd1 << (30 - i));
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += step;
            end else begin
                x -= dx; y += dy; z -= step;
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(Q30_PI)) z = longint'(Q30_PI);
        return z;
    endfunction

    function automatic t_vec_result compute_vector_op(input logic [223:0] data,
                                                      input logic [7:0] user);
        t_vec_result res;
        t_wide a[3], b[3], r[3], sf, dot, m, p, sc;
        longint unsigned la, lb;
        longint c, z;
        logic [3:0] op;
        logic deg;
        int j, k;
        op = user[3:0];
        deg = user[4];
        for (int i = 0; i < 3; i++) begin
            a[i] = $signed(data[32*i +: 32]);
            b[i] = $signed(data[32*(i+3) +: 32]);
            r[i] = 0;
        end
        sf = $signed(data[223:192]);
        sc = 0;
        res.eq = 1'b0;
        res.zl = 1'b0;
        dot = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        case (op)
            OP_ADD:    for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            OP_SUB:    for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            OP_NEGATE: for (int i = 0; i < 3; i++) r[i] = -a[i];
            OP_SCALE:  for (int i = 0; i < 3; i++) r[i] = (a[i] * sf + 32768) >>> 16;
            OP_DOT:    sc = (dot + 32768) >>> 16;
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    r[i] = (a[j] * b[k] - b[j] * a[k] + 32768) >>> 16;
                end
            end
            OP_LENGTH: sc = vec_length(a);
            OP_NORMALIZE: begin
                la = vec_length(a);
                if (la == 0) res.zl = 1'b1;
                else for (int i = 0; i < 3; i++) begin
                    m = (a[i] < 0) ? -a[i] : a[i];
                    r[i] = signed_from_mag(a[i] < 0, ((m << 16) + la / 2) / la);
                end
            end
            OP_PROJECT: begin
                lb = vec_length(b);
                if (lb == 0) res.zl = 1'b1;
                else begin
                    m = (dot < 0) ? -dot : dot;
                    sc = signed_from_mag(dot < 0, (m + lb / 2) / lb);
                end
            end
            OP_ANGLE: begin
                la = vec_length(a);
                lb = vec_length(b);
                if (la == 0 || lb == 0) res.zl = 1'b1;
                else begin
                    m = (dot < 0) ? -dot : dot;
                    p = t_wide'(la) * t_wide'(lb);
                    // cosine magnitude clamped to one before the arccosine
                    c = (m >= p) ? longint'(Q30_ONE) : longint'((m << 30) / p);
                    z = arc_cos((dot < 0) ? -c : c);
                    if (deg) sc = (z * longint'(RADDEG_Q24) + (64'sd1 << 37)) >>> 38;
                    else sc = (z + 8192) >>> 14;
                end
            end
            OP_REFLECT: begin
                sc = $signed(clamp32((dot + 32768) >>> 16));
                for (int i = 0; i < 3; i++) r[i] = a[i] - ((b[i] * sc + 16384) >>> 15);
                sc = 0;
            end
            OP_EQUALS: res.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
            default: ;
        endcase
        res.x = clamp32(r[0]);
        res.y = clamp32(r[1]);
        res.z = clamp32(r[2]);
        res.s = clamp32(sc);
        return res;
    endfunction

    assign o_pending = result_queue.size();

    always @(posedge i_clk) begin
        t_vec_result want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_checked = 0;
        end
        if (i_rst_n && i_in_valid && i_in_ready)
            result_queue.push_back(compute_vector_op(i_in_data, i_in_user));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (result_queue.size() == 0) begin
                $error("result with no item outstanding");
                o_fail_count++;
            end else begin
                want = result_queue.pop_front();
                o_checked++;
                if (i_out_data[31:0] !== want.x) begin
                    $error("res_x expected %h got %h", want.x, i_out_data[31:0]);
                    o_fail_count++;
                end
                if (i_out_data[63:32] !== want.y) begin
                    $error("res_y expected %h got %h", want.y, i_out_data[63:32]);
                    o_fail_count++;
                end
                if (i_out_data[95:64] !== want.z) begin
                    $error("res_z expected %h got %h", want.z, i_out_data[95:64]);
                    o_fail_count++;
                end
                if (i_out_data[127:96] !== want.s) begin
                    $error("res_scalar expected %h got %h", want.s, i_out_data[127:96]);
                    o_fail_count++;
                end
                if (i_out_user[0] !== want.eq) begin
                    $error("is_equal expected %b got %b", want.eq, i_out_user[0]);
                    o_fail_count++;
                end
                if (i_out_user[1] !== want.zl) begin
                    $error("zero_length expected %b got %b", want.zl, i_out_user[1]);
                    o_fail_count++;
                end
            end
        end
    end

endmodule

[dv/vector3_math_unit_tb.sv]
// ----------------------------------------------------------------------------
// vector3_math_unit_tb
// Drives directed corner items and then random vector operations through the
// math unit under several idle and backpressure mixes; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vector3_math_unit_tb;
    import v3mu_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int RANDOM_ITEMS = 1000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata = '0;  // ax, ay, az, bx, by, bz, scale_factor
    logic [7:0]   s_axis_tuser = '0;  // op[3:0], in_degrees[4], zero
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;       // res_x, res_y, res_z, res_scalar
    logic [7:0]   m_axis_tuser;       // is_equal[0], zero_length[1], zero

    int fail_count, pending, checked;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int sent = 0;

    always #10 i_clk = ~i_clk;

    vector3_math_unit DUT (.*);

    vector3_math_unit_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("vector3_math_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic send_vec_op(input logic [3:0] op, input logic [31:0] a[3],
                               input logic [31:0] b[3], input logic [31:0] sf,
                               input logic deg);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {sf, b[2], b[1], b[0], a[2], a[1], a[0]};
        s_axis_tuser <= {3'b000, deg, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        // each cycle the sender stays idle with the phase's probability
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_component();
        case ($urandom_range(9))
            0:       return 32'h80000000;
            1:       return 32'h7fffffff;
            2:       return 32'h0;
            3, 4, 5: return $urandom();
            6:       return $urandom_range(32'h0003ffff) - 32'h00020000;
            default: return $urandom_range(32'h03ffffff) - 32'h02000000;
        endcase
    endfunction

    task automatic send_random_item();
        logic [31:0] a[3], b[3];
        logic [3:0] op;
        for (int i = 0; i < 3; i++) begin
            a[i] = pick_component();
            b[i] = pick_component();
        end
        op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
        case ($urandom_range(9))
            0: b = a;
            1: for (int i = 0; i < 3; i++) b[i] = -a[i];
            2: a = '{0, 0, 0};
            3: b = '{0, 0, 0};
            default: ;
        endcase
        send_vec_op(op, a, b, pick_component(), 1'($urandom()));
    endtask

    task automatic send_directed();
        logic [31:0] mx[3], mn[3], zero[3], one[3], ex[3], ey[3];
        mx = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
        mn = '{32'h80000000, 32'h80000000, 32'h80000000};
        zero = '{0, 0, 0};
        one = '{32'h10000, 32'h20000, 32'hfffd0000};
        ex = '{32'h10000, 0, 0};
        ey = '{0, 32'h10000, 0};
        send_vec_op(OP_ADD, mx, mx, 0, 0);
        send_vec_op(OP_SUB, mn, mx, 0, 0);
        send_vec_op(OP_NEGATE, mn, zero, 0, 0);
        send_vec_op(OP_SCALE, mx, zero, 32'h80000000, 0);
        send_vec_op(OP_SCALE, one, zero, 32'h00018000, 0);
        send_vec_op(OP_DOT, mn, mn, 0, 0);
        send_vec_op(OP_CROSS, ex, ey, 0, 0);
        send_vec_op(OP_CROSS, mn, mx, 0, 0);
        send_vec_op(OP_LENGTH, mn, zero, 0, 0);
        send_vec_op(OP_LENGTH, one, zero, 0, 0);
        send_vec_op(OP_NORMALIZE, zero, zero, 0, 0);
        send_vec_op(OP_NORMALIZE, mn, zero, 0, 0);
        send_vec_op(OP_PROJECT, one, zero, 0, 0);
        send_vec_op(OP_PROJECT, mx, ex, 0, 0);
        send_vec_op(OP_ANGLE, zero, one, 0, 1);
        send_vec_op(OP_ANGLE, ex, ey, 0, 0);
        send_vec_op(OP_ANGLE, ex, ey, 0, 1);
        send_vec_op(OP_ANGLE, mx, mx, 0, 1);   // cosine lands on one
        send_vec_op(OP_ANGLE, mx, mn, 0, 0);   // cosine lands on minus one
        send_vec_op(OP_REFLECT, one, ey, 0, 0);
        send_vec_op(OP_REFLECT, mx, mn, 0, 0);
        send_vec_op(OP_EQUALS, one, one, 0, 0);
        send_vec_op(OP_EQUALS, one, ex, 0, 0);
        send_vec_op(4'd15, mx, mx, 32'hffffffff, 1);
    endtask

    initial begin
        int idle_mix[4], stall_mix[4];
        idle_mix = '{0, 63, 0, 32};
        stall_mix = '{0, 0, 63, 32};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_mix[ph];
            recv_stall_pct = stall_mix[ph];
            if (ph == 0) send_directed();
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_random_item();
        end
        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d items over all twelve ops, unused codes and corner operands,", sent);
        $display("checked %0d results under four idle and backpressure mixes", checked);
        if (fail_count == 0 && pending == 0)
            $display("vector3_math_unit_tb OK");
        else
            $display("vector3_math_unit_tb NOT OK");
        $finish;
    end

endmodule

[vector3_math_unit.f]
rtl/core/v3mu_pkg.sv
rtl/core/v3mu_isqrt.sv
rtl/core/v3mu_div.sv
rtl/core/vector3_math_unit.sv
rtl/core/v3mu_checker.sv
dv/vector3_math_unit_checker.sv
dv/vector3_math_unit_tb.sv
